// File: hw/rtl/dbdrs_pkg.sv
// shared types and constants for the dual bitmap dirty rectangle scanner
// controller/datapath command and status structs, command and result codes
// no dependencies
package dbdrs_pkg;

	localparam logic [1:0] CMD_READ  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_CTRL  = 2'd2;
	localparam logic [1:0] CMD_NEXT  = 2'd3;

	localparam logic [1:0] RES_NONE  = 2'd0;
	localparam logic [1:0] RES_READ  = 2'd1;
	localparam logic [1:0] RES_FOUND = 2'd2;
	localparam logic [1:0] RES_DONE  = 2'd3;

	localparam int CTRL_SHOW_BIT = 2;
	localparam int CTRL_NMI_BIT  = 3;

	localparam int RECIP_SHIFT = 20;
	localparam int PROD_W      = 32;

	typedef struct packed {
		logic       latch;
		logic       sweep_all;
		logic       sweep_dirty;
		logic       acc_read;
		logic       wr_check;
		logic       wr_finish;
		logic       ctrl_store;
		logic       sc_start;
		logic       sc_pos;
		logic       sc_hit;
		logic       emit;
		logic [1:0] res_kind;
	} dbdrs_ctl_t;

	typedef struct packed {
		logic box_empty;
		logic row_over;
		logic col_over;
		logic dirty_hit;
		logic sel_change;
		logic sweep_last;
	} dbdrs_sts_t;

endpackage

// File: hw/rtl/dual_bitmap_dirty_rect_scanner.sv
// dual bitmap dirty rectangle scanner, one transaction at a time, one result each.
// read steps through S_RD_A and S_RD_B, write through S_WR_A, S_WR_B and S_WR_C, control
// through S_CTRL; next cell through S_SC_START, then S_SC_POS and S_SC_CHK per cell
// (one dirty read per cell). busy drops in the strobe cycle, so a new transaction can
// start in that cycle; a flip of the shown bitmap adds a dirty marking pass with busy high.
// reset: async active-low, then a clearing pass; each pass covers every cell; results cannot stall.
module dual_bitmap_dirty_rect_scanner import dbdrs_pkg::*; #(
	parameter int COLUMNS     = 128,
	parameter int ROWS        = 224,
	parameter int LINE_OFFSET = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic        bitmap_sel,
	input  logic [14:0] offset,
	input  logic [7:0]  data,
	output logic        valid,
	output logic [7:0]  read_data,
	output logic [7:0]  pixel_x,
	output logic [7:0]  pixel_y,
	output logic [3:0]  left_pen,
	output logic [3:0]  right_pen,
	output logic        cell_found,
	output logic        scan_done,
	output logic [1:0]  tile_bank,
	output logic        nmi_enable,
	output logic [1:0]  rom_bank,
	output logic        shown_bitmap
);

	dbdrs_ctl_t ctl;
	dbdrs_sts_t sts;

	dbdrs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy),
		.valid  (valid)
	);

	dbdrs_datapath #(
		.COLUMNS     (COLUMNS),
		.ROWS        (ROWS),
		.LINE_OFFSET (LINE_OFFSET)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.sts          (sts),
		.bitmap_sel   (bitmap_sel),
		.offset       (offset),
		.data         (data),
		.read_data    (read_data),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.left_pen     (left_pen),
		.right_pen    (right_pen),
		.cell_found   (cell_found),
		.scan_done    (scan_done),
		.tile_bank    (tile_bank),
		.nmi_enable   (nmi_enable),
		.rom_bank     (rom_bank),
		.shown_bitmap (shown_bitmap)
	);

endmodule

// File: hw/rtl/dbdrs_ram.sv
// generic single-port ram with registered read
// no dependencies
module dbdrs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 28672
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/dbdrs_datapath.sv
// datapath: bitmap and dirty memories, bounding box, scan position, result registers
// depends on dbdrs_pkg and dbdrs_ram
module dbdrs_datapath import dbdrs_pkg::*; #(
	parameter int COLUMNS     = 128,
	parameter int ROWS        = 224,
	parameter int LINE_OFFSET = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dbdrs_ctl_t  ctl,
	output dbdrs_sts_t  sts,
	input  logic        bitmap_sel,
	input  logic [14:0] offset,
	input  logic [7:0]  data,
	output logic [7:0]  read_data,
	output logic [7:0]  pixel_x,
	output logic [7:0]  pixel_y,
	output logic [3:0]  left_pen,
	output logic [3:0]  right_pen,
	output logic        cell_found,
	output logic        scan_done,
	output logic [1:0]  tile_bank,
	output logic        nmi_enable,
	output logic [1:0]  rom_bank,
	output logic        shown_bitmap
);

	localparam int CELLS  = COLUMNS * ROWS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int RECIP  = (1 << RECIP_SHIFT) / COLUMNS;

	logic              sel_q;
	logic [14:0]       offset_q;
	logic [7:0]        data_q;

	logic [1:0]        tile_bank_q;
	logic              nmi_q;
	logic [1:0]        rom_bank_q;
	logic              shown_q;

	logic [COL_W-1:0]  box_min_col_q, box_max_col_q;
	logic [ROW_W-1:0]  box_min_row_q, box_max_row_q;
	logic              box_empty_q;
	logic [COL_W:0]    scan_col_q;
	logic [ROW_W:0]    scan_row_q;
	logic              scan_active_q;

	logic [PROD_W-1:0] prod_q;
	logic [ROW_W-1:0]  quo_q;
	logic [COL_W:0]    rem_q;
	logic              chg_q;

	logic [ADDR_W-1:0] addr_q;
	logic [COL_W-1:0]  hit_col_q;
	logic [ROW_W-1:0]  hit_row_q;
	logic [ADDR_W-1:0] sweep_q;

	logic [7:0]        read_data_q, pixel_x_q, pixel_y_q;
	logic [3:0]        left_pen_q, right_pen_q;
	logic              found_q, done_q;

	logic              in_range;
	logic [ADDR_W-1:0] off_addr;
	logic [7:0]        bm_rdata [2];
	logic              dt_rdata [2];
	logic [7:0]        cur_byte;
	logic [7:0]        shown_byte;
	logic              changed;
	logic [COL_W:0]    col_c;
	logic              col_over;
	logic              row_over;
	logic [ADDR_W-1:0] scan_addr;
	logic [ROW_W-1:0]  q_est;
	logic [COL_W:0]    rem_adj;
	logic [COL_W-1:0]  grow_col;
	logic [ROW_W-1:0]  grow_row;
	logic [ADDR_W-1:0] mem_addr;
	logic [7:0]        bm_wdata;
	logic              dt_wdata;
	logic              sweeping;

	assign in_range   = 32'(offset_q) < CELLS;
	assign off_addr   = ADDR_W'(offset_q);
	assign cur_byte   = bm_rdata[sel_q];
	assign shown_byte = bm_rdata[shown_q];
	assign changed    = in_range && (cur_byte != data_q);

	assign col_c     = (scan_col_q < {1'b0, box_min_col_q}) ? {1'b0, box_min_col_q} : scan_col_q;
	assign col_over  = col_c > {1'b0, box_max_col_q};
	assign row_over  = scan_row_q > {1'b0, box_max_row_q};
	assign scan_addr = ADDR_W'(32'(scan_row_q[ROW_W-1:0]) * COLUMNS
		+ 32'(col_c[COL_W-1:0]));

	assign q_est   = ROW_W'(prod_q >> RECIP_SHIFT);
	assign rem_adj = rem_q - (COL_W+1)'(COLUMNS);
	always_comb begin
		if (rem_q >= (COL_W+1)'(COLUMNS)) begin
			grow_col = rem_adj[COL_W-1:0];
			grow_row = quo_q + 1'b1;
		end else begin
			grow_col = rem_q[COL_W-1:0];
			grow_row = quo_q;
		end
	end

	assign sweeping = ctl.sweep_all || ctl.sweep_dirty;

	always_comb begin
		if (sweeping) begin
			mem_addr = sweep_q;
		end else if (ctl.sc_pos) begin
			mem_addr = scan_addr;
		end else if (ctl.sc_hit) begin
			mem_addr = addr_q;
		end else begin
			mem_addr = off_addr;
		end
	end

	assign bm_wdata = ctl.sweep_all ? 8'd0 : data_q;
	assign dt_wdata = !ctl.sc_hit;

	for (genvar k = 0; k < 2; k++) begin : g_bank
		logic bm_we;
		logic dt_we;
		logic [0:0] dt_rd;

		assign bm_we = ctl.sweep_all || (ctl.wr_check && changed && sel_q == 1'(k));
		assign dt_we = sweeping || (ctl.wr_check && changed && sel_q == 1'(k))
			|| (ctl.sc_hit && shown_q == 1'(k));

		dbdrs_ram #(.WIDTH(8), .DEPTH(CELLS)) u_bitmap (
			.clk   (clk),
			.we    (bm_we),
			.addr  (mem_addr),
			.wdata (bm_wdata),
			.rdata (bm_rdata[k])
		);

		dbdrs_ram #(.WIDTH(1), .DEPTH(CELLS)) u_dirty (
			.clk   (clk),
			.we    (dt_we),
			.addr  (mem_addr),
			.wdata (dt_wdata),
			.rdata (dt_rd)
		);

		assign dt_rdata[k] = dt_rd[0];
	end

	assign sts.box_empty  = box_empty_q;
	assign sts.row_over   = row_over;
	assign sts.col_over   = col_over;
	assign sts.dirty_hit  = dt_rdata[shown_q];
	assign sts.sel_change = data_q[CTRL_SHOW_BIT] != shown_q;
	assign sts.sweep_last = sweep_q == ADDR_W'(CELLS - 1);

	// operand and result registers
	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			sel_q    <= bitmap_sel;
			offset_q <= offset;
			data_q   <= data;
		end
		if (ctl.acc_read) begin
			prod_q <= PROD_W'(32'(offset_q) * RECIP);
		end
		if (ctl.wr_check) begin
			quo_q <= q_est;
			rem_q <= (COL_W+1)'(32'(offset_q) - 32'(q_est) * COLUMNS);
			chg_q <= changed;
		end
		if (ctl.sc_pos && !row_over && !col_over) begin
			addr_q    <= scan_addr;
			hit_col_q <= col_c[COL_W-1:0];
			hit_row_q <= scan_row_q[ROW_W-1:0];
		end
		if (ctl.emit) begin
			read_data_q <= 8'd0;
			pixel_x_q   <= 8'd0;
			pixel_y_q   <= 8'd0;
			left_pen_q  <= 4'd0;
			right_pen_q <= 4'd0;
			found_q     <= 1'b0;
			done_q      <= 1'b0;
			case (ctl.res_kind)
				RES_READ: begin
					read_data_q <= in_range ? cur_byte : 8'd0;
				end
				RES_FOUND: begin
					pixel_x_q   <= 8'({hit_col_q, 1'b0});
					pixel_y_q   <= 8'(32'(hit_row_q) + LINE_OFFSET);
					left_pen_q  <= shown_byte[7:4];
					right_pen_q <= shown_byte[3:0];
					found_q     <= 1'b1;
				end
				RES_DONE: begin
					done_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// control, box and scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_bank_q   <= 2'd0;
			nmi_q         <= 1'b0;
			rom_bank_q    <= 2'd0;
			shown_q       <= 1'b0;
			box_min_col_q <= '0;
			box_max_col_q <= COL_W'(COLUMNS - 1);
			box_min_row_q <= '0;
			box_max_row_q <= ROW_W'(ROWS - 1);
			box_empty_q   <= 1'b0;
			scan_col_q    <= '0;
			scan_row_q    <= '0;
			scan_active_q <= 1'b0;
			sweep_q       <= '0;
		end else begin
			if (sweeping) begin
				sweep_q <= sts.sweep_last ? '0 : sweep_q + 1'b1;
			end
			if (ctl.ctrl_store) begin
				tile_bank_q <= data_q[1:0];
				nmi_q       <= data_q[CTRL_NMI_BIT];
				rom_bank_q  <= data_q[5:4];
				if (sts.sel_change) begin
					shown_q       <= data_q[CTRL_SHOW_BIT];
					box_min_col_q <= '0;
					box_max_col_q <= COL_W'(COLUMNS - 1);
					box_min_row_q <= '0;
					box_max_row_q <= ROW_W'(ROWS - 1);
					box_empty_q   <= 1'b0;
				end
			end
			if (ctl.wr_finish && chg_q) begin
				if (box_empty_q) begin
					box_min_col_q <= grow_col;
					box_max_col_q <= grow_col;
					box_min_row_q <= grow_row;
					box_max_row_q <= grow_row;
					box_empty_q   <= 1'b0;
				end else begin
					if (grow_col < box_min_col_q) box_min_col_q <= grow_col;
					if (grow_col > box_max_col_q) box_max_col_q <= grow_col;
					if (grow_row < box_min_row_q) box_min_row_q <= grow_row;
					if (grow_row > box_max_row_q) box_max_row_q <= grow_row;
				end
			end
			if (ctl.sc_start) begin
				if (box_empty_q) begin
					scan_active_q <= 1'b0;
				end else if (!scan_active_q) begin
					scan_active_q <= 1'b1;
					scan_row_q    <= {1'b0, box_min_row_q};
					scan_col_q    <= {1'b0, box_min_col_q};
				end
			end
			if (ctl.sc_pos) begin
				if (row_over) begin
					scan_active_q <= 1'b0;
					box_empty_q   <= 1'b1;
				end else if (col_over) begin
					scan_row_q <= scan_row_q + 1'b1;
					scan_col_q <= {1'b0, box_min_col_q};
				end else begin
					scan_col_q <= col_c + 1'b1;
				end
			end
		end
	end

	assign read_data    = read_data_q;
	assign pixel_x      = pixel_x_q;
	assign pixel_y      = pixel_y_q;
	assign left_pen     = left_pen_q;
	assign right_pen    = right_pen_q;
	assign cell_found   = found_q;
	assign scan_done    = done_q;
	assign tile_bank    = tile_bank_q;
	assign nmi_enable   = nmi_q;
	assign rom_bank     = rom_bank_q;
	assign shown_bitmap = shown_q;

	a_active_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(scan_active_q && box_empty_q))
		else $error("scan active with empty box");

	a_box_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		!box_empty_q |-> (box_min_col_q <= box_max_col_q && box_min_row_q <= box_max_row_q))
		else $error("bounding box inverted");

endmodule

// File: hw/rtl/dbdrs_ctrl.sv
// controller state machine: sequences memory accesses, scan walk and clearing passes
// depends on dbdrs_pkg
module dbdrs_ctrl import dbdrs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] cmd,
	input  dbdrs_sts_t sts,
	output dbdrs_ctl_t ctl,
	output logic       busy,
	output logic       valid
);

	localparam logic [3:0] S_INIT     = 4'd0;
	localparam logic [3:0] S_IDLE     = 4'd1;
	localparam logic [3:0] S_RD_A     = 4'd2;
	localparam logic [3:0] S_RD_B     = 4'd3;
	localparam logic [3:0] S_WR_A     = 4'd4;
	localparam logic [3:0] S_WR_B     = 4'd5;
	localparam logic [3:0] S_WR_C     = 4'd6;
	localparam logic [3:0] S_CTRL     = 4'd7;
	localparam logic [3:0] S_SWEEP    = 4'd8;
	localparam logic [3:0] S_SC_START = 4'd9;
	localparam logic [3:0] S_SC_POS   = 4'd10;
	localparam logic [3:0] S_SC_CHK   = 4'd11;

	logic [3:0] state_q, state_d;
	logic       valid_q;

	always_comb begin
		ctl     = '0;
		state_d = state_q;
		case (state_q)
			S_INIT: begin
				ctl.sweep_all = 1'b1;
				if (sts.sweep_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					ctl.latch = 1'b1;
					case (cmd)
						CMD_READ:  state_d = S_RD_A;
						CMD_WRITE: state_d = S_WR_A;
						CMD_CTRL:  state_d = S_CTRL;
						CMD_NEXT:  state_d = S_SC_START;
						default:   state_d = S_IDLE;
					endcase
				end
			end
			S_RD_A: begin
				ctl.acc_read = 1'b1;
				state_d      = S_RD_B;
			end
			S_RD_B: begin
				ctl.emit     = 1'b1;
				ctl.res_kind = RES_READ;
				state_d      = S_IDLE;
			end
			S_WR_A: begin
				ctl.acc_read = 1'b1;
				state_d      = S_WR_B;
			end
			S_WR_B: begin
				ctl.wr_check = 1'b1;
				state_d      = S_WR_C;
			end
			S_WR_C: begin
				ctl.wr_finish = 1'b1;
				ctl.emit      = 1'b1;
				ctl.res_kind  = RES_NONE;
				state_d       = S_IDLE;
			end
			S_CTRL: begin
				ctl.ctrl_store = 1'b1;
				ctl.emit       = 1'b1;
				ctl.res_kind   = RES_NONE;
				state_d        = sts.sel_change ? S_SWEEP : S_IDLE;
			end
			S_SWEEP: begin
				ctl.sweep_dirty = 1'b1;
				if (sts.sweep_last) state_d = S_IDLE;
			end
			S_SC_START: begin
				ctl.sc_start = 1'b1;
				if (sts.box_empty) begin
					ctl.emit     = 1'b1;
					ctl.res_kind = RES_DONE;
					state_d      = S_IDLE;
				end else begin
					state_d = S_SC_POS;
				end
			end
			S_SC_POS: begin
				ctl.sc_pos = 1'b1;
				if (sts.row_over) begin
					ctl.emit     = 1'b1;
					ctl.res_kind = RES_DONE;
					state_d      = S_IDLE;
				end else if (!sts.col_over) begin
					state_d = S_SC_CHK;
				end
			end
			S_SC_CHK: begin
				if (sts.dirty_hit) begin
					ctl.sc_hit   = 1'b1;
					ctl.emit     = 1'b1;
					ctl.res_kind = RES_FOUND;
					state_d      = S_IDLE;
				end else begin
					state_d = S_SC_POS;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			valid_q <= ctl.emit;
		end
	end

	assign busy  = state_q != S_IDLE;
	assign valid = valid_q;

	a_valid_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> $past(state_q != S_IDLE))
		else $error("result strobe without a transaction in progress");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |=> !valid_q)
		else $error("more than one result for a transaction");

endmodule

// File: verif/bitmap_scan_checker.sv
// checker for the dual bitmap dirty rectangle scanner: predicts every transaction
// and compares each result strobe against the oldest prediction
// depends on dbdrs_pkg for command codes and control bit positions
module bitmap_scan_checker import dbdrs_pkg::*; #(
	parameter int COLUMNS     = 128,
	parameter int ROWS        = 224,
	parameter int LINE_OFFSET = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  cmd,
	input  logic        bitmap_sel,
	input  logic [14:0] offset,
	input  logic [7:0]  data,
	input  logic        valid,
	input  logic [7:0]  read_data,
	input  logic [7:0]  pixel_x,
	input  logic [7:0]  pixel_y,
	input  logic [3:0]  left_pen,
	input  logic [3:0]  right_pen,
	input  logic        cell_found,
	input  logic        scan_done,
	input  logic [1:0]  tile_bank,
	input  logic        nmi_enable,
	input  logic [1:0]  rom_bank,
	input  logic        shown_bitmap,
	output int          errors,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CELLS = COLUMNS * ROWS;

	typedef struct packed {
		logic [7:0] rd;
		logic [7:0] px;
		logic [7:0] py;
		logic [3:0] lp;
		logic [3:0] rp;
		logic       found;
		logic       done;
		logic [1:0] tile;
		logic       nmi;
		logic [1:0] rom;
		logic       shown;
	} cell_report_t;

	bit [7:0] pix [2][CELLS];
	bit dirty [2][CELLS];
	int box_c0, box_c1, box_r0, box_r1;
	bit box_clear;
	bit shown;
	logic [4:0] ctrl_bits;
	int walk_col, walk_row;
	bit walking;
	cell_report_t due_reports [$];

	function automatic void mark_all_dirty();
		int i;
		for (i = 0; i < CELLS; i++) begin
			dirty[0][i] = 1'b1;
			dirty[1][i] = 1'b1;
		end
		box_c0 = 0;
		box_c1 = COLUMNS - 1;
		box_r0 = 0;
		box_r1 = ROWS - 1;
		box_clear = 1'b0;
	endfunction

	function automatic void clear_model();
		int i;
		for (i = 0; i < CELLS; i++) begin
			pix[0][i] = '0;
			pix[1][i] = '0;
		end
		mark_all_dirty();
		shown = 1'b0;
		ctrl_bits = '0;
		walk_col = 0;
		walk_row = 0;
		walking = 1'b0;
	endfunction

	function automatic void grow_box(int col, int row);
		if (box_clear) begin
			box_c0 = col;
			box_c1 = col;
			box_r0 = row;
			box_r1 = row;
			box_clear = 1'b0;
		end else begin
			if (col < box_c0) box_c0 = col;
			if (col > box_c1) box_c1 = col;
			if (row < box_r0) box_r0 = row;
			if (row > box_r1) box_r1 = row;
		end
	endfunction

	function automatic bit next_dirty(output int addr);
		int a;
		addr = 0;
		if (box_clear) begin
			walking = 1'b0;
			return 1'b0;
		end
		if (!walking) begin
			walking = 1'b1;
			walk_row = box_r0;
			walk_col = box_c0;
		end
		while (walk_row <= box_r1) begin
			if (walk_col < box_c0) walk_col = box_c0;
			while (walk_col <= box_c1) begin
				a = walk_row * COLUMNS + walk_col;
				walk_col++;
				if (a < CELLS && dirty[shown][a]) begin
					dirty[shown][a] = 1'b0;
					addr = a;
					return 1'b1;
				end
			end
			walk_row++;
			walk_col = box_c0;
		end
		walking = 1'b0;
		box_clear = 1'b1;
		return 1'b0;
	endfunction

	function automatic cell_report_t predict_report(logic [1:0] c, logic s, logic [14:0] o,
			logic [7:0] d);
		cell_report_t r;
		int a;
		bit [7:0] b;
		r = '0;
		a = int'(o);
		case (c)
			CMD_READ: begin
				if (a < CELLS) r.rd = pix[s][a];
			end
			CMD_WRITE: begin
				if (a < CELLS && pix[s][a] != d) begin
					pix[s][a] = d;
					dirty[s][a] = 1'b1;
					grow_box(a % COLUMNS, a / COLUMNS);
				end
			end
			CMD_CTRL: begin
				ctrl_bits = {d[5:4], d[CTRL_NMI_BIT], d[1:0]};
				if (d[CTRL_SHOW_BIT] != shown) begin
					shown = d[CTRL_SHOW_BIT];
					mark_all_dirty();
				end
			end
			default: begin
				if (next_dirty(a)) begin
					b = pix[shown][a];
					r.px = 8'(2 * (a % COLUMNS));
					r.py = 8'(a / COLUMNS + LINE_OFFSET);
					r.lp = b[7:4];
					r.rp = b[3:0];
					r.found = 1'b1;
				end else begin
					r.done = 1'b1;
				end
			end
		endcase
		r.tile = ctrl_bits[1:0];
		r.nmi = ctrl_bits[2];
		r.rom = ctrl_bits[4:3];
		r.shown = shown;
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		$display("mismatch at %0t ns: %s", $time, msg);
		errors++;
	endtask

	task automatic check_field(string name, int want, int got);
		if (want != got)
			report_mismatch($sformatf("%s expected %0d, got %0d", name, want, got));
	endtask

	always @(posedge clk) begin : watch
		cell_report_t want, got;
		if (!arst_n) begin
			clear_model();
			due_reports.delete();
		end else begin
			if (valid) begin
				got = {read_data, pixel_x, pixel_y, left_pen, right_pen, cell_found, scan_done,
					tile_bank, nmi_enable, rom_bank, shown_bitmap};
				if (due_reports.size() == 0) begin
					report_mismatch("result strobe with no transaction outstanding");
				end else begin
					want = due_reports.pop_front();
					check_field("read_data", int'(want.rd), int'(got.rd));
					check_field("pixel_x", int'(want.px), int'(got.px));
					check_field("pixel_y", int'(want.py), int'(got.py));
					check_field("left_pen", int'(want.lp), int'(got.lp));
					check_field("right_pen", int'(want.rp), int'(got.rp));
					check_field("cell_found", int'(want.found), int'(got.found));
					check_field("scan_done", int'(want.done), int'(got.done));
					check_field("tile_bank", int'(want.tile), int'(got.tile));
					check_field("nmi_enable", int'(want.nmi), int'(got.nmi));
					check_field("rom_bank", int'(want.rom), int'(got.rom));
					check_field("shown_bitmap", int'(want.shown), int'(got.shown));
				end
			end
			if (start && !busy)
				due_reports.push_back(predict_report(cmd, bitmap_sel, offset, data));
		end
		outstanding <= due_reports.size();
	end

endmodule

// File: verif/tb.sv
// top of the scanner testbench: clock, reset, command stimulus and the verdict
// depends on dbdrs_pkg, dual_bitmap_dirty_rect_scanner and bitmap_scan_checker
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import dbdrs_pkg::*;

	localparam int COLS         = 128;
	localparam int LINES        = 224;
	localparam int CELLS        = COLS * LINES;
	localparam int RANDOM_ITEMS = 1800;
	localparam int CYCLE_LIMIT  = 4000000;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [1:0]  cmd = CMD_READ;
	logic        bitmap_sel = 1'b0;
	logic [14:0] offset = '0;
	logic [7:0]  data = '0;
	logic        busy;
	logic        valid;
	logic [7:0]  read_data;
	logic [7:0]  pixel_x;
	logic [7:0]  pixel_y;
	logic [3:0]  left_pen;
	logic [3:0]  right_pen;
	logic        cell_found;
	logic        scan_done;
	logic [1:0]  tile_bank;
	logic        nmi_enable;
	logic [1:0]  rom_bank;
	logic        shown_bitmap;
	int          errors;
	int          outstanding;

	int unsigned cycle_count = 0;
	int          rand_items = 0;
	int          burst_left = 0;
	int          flips = 0;
	logic        shown_now = 1'b0;
	bit          window_open = 1'b0;
	int          win_col, win_row, win_w, win_h;

	dual_bitmap_dirty_rect_scanner #(
		.COLUMNS(COLS),
		.ROWS(LINES),
		.LINE_OFFSET(16)
	) i_dut (.*);

	bitmap_scan_checker #(
		.COLUMNS(COLS),
		.ROWS(LINES),
		.LINE_OFFSET(16)
	) i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic send(input logic [1:0] c, input logic s, input logic [14:0] o,
			input logic [7:0] d);
		start <= 1'b1;
		cmd <= c;
		bitmap_sel <= s;
		offset <= o;
		data <= d;
		do @(posedge clk); while (busy);
	endtask

	task automatic idle(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic settle();
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic put(input logic [1:0] c, input logic s, input logic [14:0] o,
			input logic [7:0] d);
		send(c, s, o, d);
		if (!(c == CMD_WRITE && o >= CELLS)) rand_items++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			idle($urandom_range(1, 6));
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 5);
		end
	endtask

	task automatic flip_shown();
		logic [7:0] d;
		d = 8'($urandom_range(0, 255));
		shown_now = ~shown_now;
		d[CTRL_SHOW_BIT] = shown_now;
		settle();
		send(CMD_CTRL, 1'($urandom_range(0, 1)), 15'($urandom_range(0, 32767)), d);
		flips++;
		settle();
		window_open = 1'b0;
	endtask

	task automatic run_frame();
		int n, k, r, c;
		logic [14:0] o;
		logic [7:0] d;
		logic s;
		if (!window_open) begin
			win_w = $urandom_range(1, 8);
			win_h = $urandom_range(1, 8);
			win_col = $urandom_range(0, COLS - win_w);
			win_row = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 4) :
				$urandom_range(0, LINES - win_h);
			window_open = 1'b1;
		end
		n = $urandom_range(1, 8);
		for (k = 0; k < n; k++) begin
			r = win_row + $urandom_range(0, win_h - 1);
			c = win_col + $urandom_range(0, win_w - 1);
			o = 15'(r * COLS + c);
			d = 8'($urandom_range(0, 255));
			s = ($urandom_range(0, 3) == 0) ? ~shown_now : shown_now;
			case ($urandom_range(0, 11))
				0: put(CMD_READ, s, o, d);
				1: put(CMD_READ, 1'($urandom_range(0, 1)), 15'($urandom_range(0, 32767)), d);
				2: begin
					d[CTRL_SHOW_BIT] = shown_now;
					put(CMD_CTRL, s, o, d);
				end
				3: put(CMD_WRITE, s, 15'($urandom_range(CELLS, 32767)), d);
				4: put(CMD_NEXT, s, o, d);
				5: begin
					put(CMD_WRITE, s, o, d);
					put(CMD_WRITE, s, o, d);
				end
				default: put(CMD_WRITE, s, o, d);
			endcase
		end
		n = $urandom_range(0, 3);
		for (k = 0; k < n; k++)
			put(CMD_NEXT, 1'($urandom_range(0, 1)), 15'($urandom_range(0, 32767)),
				8'($urandom_range(0, 255)));
		if ($urandom_range(0, 3) == 0) window_open = 1'b0;
		if ($urandom_range(0, 15) == 0) settle();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// full box, every cell dirty
		put(CMD_READ, 1'b0, 15'd0, 8'h00);
		put(CMD_READ, 1'b1, 15'd28671, 8'hff);
		put(CMD_READ, 1'b0, 15'h7fff, 8'h00);
		put(CMD_WRITE, 1'b0, 15'd0, 8'hff);
		put(CMD_WRITE, 1'b0, 15'd0, 8'hff);
		put(CMD_WRITE, 1'b1, 15'd28672, 8'ha5);
		put(CMD_READ, 1'b0, 15'd0, 8'h00);
		put(CMD_READ, 1'b1, 15'd28672, 8'h00);
		put(CMD_CTRL, 1'b0, 15'd0, 8'hfb);
		put(CMD_NEXT, 1'b0, 15'd0, 8'h00);
		put(CMD_NEXT, 1'b1, 15'h7fff, 8'hff);
		put(CMD_CTRL, 1'b1, 15'h7fff, 8'h00);
		settle();

		// walk along the top row with writes ahead of and behind the walk
		put(CMD_WRITE, 1'b0, 15'd5, 8'h9c);
		put(CMD_NEXT, 1'b0, 15'd0, 8'h00);
		put(CMD_WRITE, 1'b0, 15'd28671, 8'h5a);
		put(CMD_NEXT, 1'b0, 15'd0, 8'h00);
		put(CMD_NEXT, 1'b0, 15'd0, 8'h00);
		put(CMD_WRITE, 1'b1, 15'd0, 8'h3c);
		put(CMD_NEXT, 1'b0, 15'd0, 8'h00);
		put(CMD_WRITE, 1'b0, 15'(5 * COLS + 10), 8'h12);
		put(CMD_WRITE, 1'b0, 15'(8 * COLS + 30), 8'h34);
		put(CMD_NEXT, 1'b0, 15'd0, 8'h00);
		put(CMD_WRITE, 1'b0, 15'(6 * COLS + 2), 8'h56);
		put(CMD_NEXT, 1'b0, 15'd0, 8'h00);
		put(CMD_WRITE, 1'b0, 15'd1, 8'h00);
		put(CMD_NEXT, 1'b0, 15'd0, 8'h00);
		settle();

		rand_items = 0;
		while (rand_items < RANDOM_ITEMS) begin
			if ((flips == 0 && rand_items >= RANDOM_ITEMS / 3) ||
					(flips == 1 && rand_items >= 2 * RANDOM_ITEMS / 3))
				flip_shown();
			run_frame();
		end

		settle();
		idle(16);
		if (errors == 0 && outstanding == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
